// ===== design/pidtm_pkg.sv =====
// Shared constants, register codes and types of the two-mode PID controller.
`timescale 1ns / 1ps
`default_nettype none

package pidtm_pkg;

   // Default parameter values.
   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int GAIN_FRAC_BITS_DEF = 8;

   // Fixed field widths.
   localparam int GAIN_WIDTH      = 16;
   localparam int DEADBAND_WIDTH  = 16;
   localparam int INTEG_WIDTH     = 32;
   localparam int DRIVE_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MODE         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_P       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_I       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_D       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEADBAND     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTEGRAL_CAP = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUTPUT_CAP   = 3'd7;

   // Controller forms.
   localparam logic MODE_INCREMENTAL = 1'b0;
   localparam logic MODE_POSITIONAL  = 1'b1;

   // Configuration registers whose widths do not follow the sample width.
   typedef struct packed {
      logic                           mode;
      logic signed [GAIN_WIDTH-1:0]   gain_p;
      logic signed [GAIN_WIDTH-1:0]   gain_i;
      logic signed [GAIN_WIDTH-1:0]   gain_d;
      logic [DEADBAND_WIDTH-1:0]      deadband;
      logic signed [INTEG_WIDTH-1:0]  integral_cap;
      logic [DRIVE_WIDTH-1:0]         output_cap;
   } pidtm_cfg_type;

   // Load enables of the pipeline stages, one per stage register after the input register.
   typedef struct packed {
      logic ld_err;
      logic ld_op;
      logic ld_prod;
      logic ld_sum;
      logic ld_out;
   } pidtm_ctrl_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Widths of the datapath, all derived from the sample width.
   function automatic int err_width(input int sw);
      return sw + 1;
   endfunction

   function automatic int opp_width(input int sw);
      return sw + 2;
   endfunction

   function automatic int opd_width(input int sw);
      return sw + 3;
   endfunction

   function automatic int opi_width(input int sw);
      return max_int(sw + 1, INTEG_WIDTH);
   endfunction

   function automatic int term_width(input int sw);
      return GAIN_WIDTH + max_int(sw + 3, max_int(sw + 1, INTEG_WIDTH)) + 2;
   endfunction

endpackage

`default_nettype wire

// ===== design/pid_controller_two_mode.sv =====
// Top level of the two-mode PID controller: pipeline control and output stage.
// A sample passes through the input, error, operand, product, sum and output registers in that order.
// Throughput: one sample per cycle while the output is not stalled, through a six-register pipeline.
// The integral and output feedback loops each close inside a single stage.
// Reset is synchronous and active high; it clears the valid bits, the
// configuration registers, the error history, the integral and the output.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_two_mode import pidtm_pkg::*; #(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Sample channel.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0 up: measured, zero padding to whole bytes.
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,
   // Drive channel.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // Fields from bit 0 up: drive.
   output logic [DRIVE_WIDTH-1:0]                   rsp_tdata,
   // Configuration write channel.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]          csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]           csr_data
);

   localparam int EW  = err_width(SAMPLE_WIDTH);
   localparam int PW  = opp_width(SAMPLE_WIDTH);
   localparam int DW  = opd_width(SAMPLE_WIDTH);
   localparam int IOW = opi_width(SAMPLE_WIDTH);
   localparam int TW  = term_width(SAMPLE_WIDTH);
   localparam int OW  = TW + 1;

   pidtm_cfg_type                  cfg;
   pidtm_ctrl_type                 ctrl;
   logic signed [SAMPLE_WIDTH-1:0] target;

   // One valid bit per stage register, from the input register to the result.
   logic v_in_ff,   v_in_in;
   logic v_err_ff,  v_err_in;
   logic v_op_ff,   v_op_in;
   logic v_prod_ff, v_prod_in;
   logic v_sum_ff,  v_sum_in;
   logic v_out_ff,  v_out_in;

   logic rdy_in, rdy_err, rdy_op, rdy_prod, rdy_sum, rdy_out;

   logic signed [SAMPLE_WIDTH-1:0] meas_ff;
   logic signed [EW-1:0]           err;
   logic signed [PW-1:0]           op_p;
   logic signed [IOW-1:0]          op_i;
   logic signed [DW-1:0]           op_d;
   logic signed [TW-1:0]           sum;

   logic [DRIVE_WIDTH-1:0]         acc_ff, acc_in;
   logic signed [OW-1:0]           out_sum;

   // A stage takes a new transaction when it is empty or its content moves on,
   // so bubbles fill up even while a finished result waits on the output.
   always_comb begin
      rdy_out  = !v_out_ff  || rsp_tready;
      rdy_sum  = !v_sum_ff  || rdy_out;
      rdy_prod = !v_prod_ff || rdy_sum;
      rdy_op   = !v_op_ff   || rdy_prod;
      rdy_err  = !v_err_ff  || rdy_op;
      rdy_in   = !v_in_ff   || rdy_err;

      ctrl.ld_err  = v_in_ff   && rdy_err;
      ctrl.ld_op   = v_err_ff  && rdy_op;
      ctrl.ld_prod = v_op_ff   && rdy_prod;
      ctrl.ld_sum  = v_prod_ff && rdy_sum;
      ctrl.ld_out  = v_sum_ff  && rdy_out;

      v_in_in   = rdy_in   ? req_tvalid : v_in_ff;
      v_err_in  = rdy_err  ? v_in_ff    : v_err_ff;
      v_op_in   = rdy_op   ? v_err_ff   : v_op_ff;
      v_prod_in = rdy_prod ? v_op_ff    : v_prod_ff;
      v_sum_in  = rdy_sum  ? v_prod_ff  : v_sum_ff;
      v_out_in  = rdy_out  ? v_sum_ff   : v_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff   <= 1'b0;
         v_err_ff  <= 1'b0;
         v_op_ff   <= 1'b0;
         v_prod_ff <= 1'b0;
         v_sum_ff  <= 1'b0;
         v_out_ff  <= 1'b0;
      end else begin
         v_in_ff   <= v_in_in;
         v_err_ff  <= v_err_in;
         v_op_ff   <= v_op_in;
         v_prod_ff <= v_prod_in;
         v_sum_ff  <= v_sum_in;
         v_out_ff  <= v_out_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_tvalid && rdy_in) begin
         meas_ff <= req_tdata[SAMPLE_WIDTH-1:0];
      end
   end

   pidtm_csr #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .target    (target)
   );

   pidtm_error #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_error (
      .clock    (clock),
      .ctrl     (ctrl),
      .measured (meas_ff),
      .target   (target),
      .deadband (cfg.deadband),
      .err      (err)
   );

   pidtm_state #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_state (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .mode         (cfg.mode),
      .integral_cap (cfg.integral_cap),
      .err          (err),
      .op_p         (op_p),
      .op_i         (op_i),
      .op_d         (op_d)
   );

   pidtm_terms #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_terms (
      .clock  (clock),
      .ctrl   (ctrl),
      .gain_p (cfg.gain_p),
      .gain_i (cfg.gain_i),
      .gain_d (cfg.gain_d),
      .op_p   (op_p),
      .op_i   (op_i),
      .op_d   (op_d),
      .sum    (sum)
   );

   // Output stage. The incremental form adds the step to the stored output;
   // the positional form uses the sum as it stands. Either way the value is
   // clamped to zero from below and to the output cap from above, and it is
   // kept as the stored output for the next transaction.
   always_comb begin
      if (cfg.mode == MODE_INCREMENTAL) begin
         out_sum = OW'(sum) + OW'(signed'({1'b0, acc_ff}));
      end else begin
         out_sum = OW'(sum);
      end

      if (out_sum < 0) begin
         acc_in = '0;
      end else if (out_sum > OW'(signed'({1'b0, cfg.output_cap}))) begin
         acc_in = cfg.output_cap;
      end else begin
         acc_in = out_sum[DRIVE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.ld_out) begin
         acc_ff <= acc_in;
      end
   end

   assign req_tready = rdy_in;
   assign rsp_tvalid = v_out_ff;
   assign rsp_tdata  = acc_ff;

endmodule

`default_nettype wire

// ===== design/pidtm_csr.sv =====
// Configuration register file of the two-mode PID controller.
`timescale 1ns / 1ps
`default_nettype none

module pidtm_csr import pidtm_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]        csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]         csr_data,
   output pidtm_cfg_type                          cfg,
   output logic signed [SAMPLE_WIDTH-1:0]         target
);

   pidtm_cfg_type                  cfg_ff, cfg_in;
   logic signed [SAMPLE_WIDTH-1:0] target_ff, target_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in    = cfg_ff;
      target_in = target_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MODE:         cfg_in.mode         = csr_data[0];
            REG_TARGET:       target_in           = csr_data[SAMPLE_WIDTH-1:0];
            REG_GAIN_P:       cfg_in.gain_p       = csr_data[GAIN_WIDTH-1:0];
            REG_GAIN_I:       cfg_in.gain_i       = csr_data[GAIN_WIDTH-1:0];
            REG_GAIN_D:       cfg_in.gain_d       = csr_data[GAIN_WIDTH-1:0];
            REG_DEADBAND:     cfg_in.deadband     = csr_data[DEADBAND_WIDTH-1:0];
            REG_INTEGRAL_CAP: cfg_in.integral_cap = csr_data[INTEG_WIDTH-1:0];
            REG_OUTPUT_CAP:   cfg_in.output_cap   = csr_data[DRIVE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         target_ff <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         target_ff <= target_in;
      end
   end

   assign cfg    = cfg_ff;
   assign target = target_ff;

endmodule

`default_nettype wire

// ===== design/pidtm_error.sv =====
// Error stage: set point minus sample, with the deadband applied.
`timescale 1ns / 1ps
`default_nettype none

module pidtm_error import pidtm_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                                        clock,
   input  wire pidtm_ctrl_type                              ctrl,
   input  wire logic signed [SAMPLE_WIDTH-1:0]              measured,
   input  wire logic signed [SAMPLE_WIDTH-1:0]              target,
   input  wire logic [DEADBAND_WIDTH-1:0]                   deadband,
   output logic signed [err_width(SAMPLE_WIDTH)-1:0]        err
);

   localparam int EW = err_width(SAMPLE_WIDTH);
   localparam int CW = max_int(EW, DEADBAND_WIDTH);

   logic signed [EW-1:0] diff;
   logic [EW-1:0]        mag;
   logic signed [EW-1:0] err_ff, err_in;

   always_comb begin
      diff   = EW'(target) - EW'(measured);
      mag    = diff[EW-1] ? unsigned'(-diff) : unsigned'(diff);
      // Small errors inside the deadband do not move the controller.
      err_in = (CW'(mag) < CW'(deadband)) ? '0 : diff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_err) begin
         err_ff <= err_in;
      end
   end

   assign err = err_ff;

endmodule

`default_nettype wire

// ===== design/pidtm_state.sv =====
// History stage: error history, integral sum and the three gain operands.
`timescale 1ns / 1ps
`default_nettype none

module pidtm_state import pidtm_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire pidtm_ctrl_type                              ctrl,
   input  wire logic                                        mode,
   input  wire logic signed [INTEG_WIDTH-1:0]               integral_cap,
   input  wire logic signed [err_width(SAMPLE_WIDTH)-1:0]   err,
   output logic signed [opp_width(SAMPLE_WIDTH)-1:0]        op_p,
   output logic signed [opi_width(SAMPLE_WIDTH)-1:0]        op_i,
   output logic signed [opd_width(SAMPLE_WIDTH)-1:0]        op_d
);

   localparam int EW   = err_width(SAMPLE_WIDTH);
   localparam int PW   = opp_width(SAMPLE_WIDTH);
   localparam int DW   = opd_width(SAMPLE_WIDTH);
   localparam int IOW  = opi_width(SAMPLE_WIDTH);
   localparam int SUMW = max_int(EW, INTEG_WIDTH) + 1;

   localparam logic signed [INTEG_WIDTH-1:0] INT_MAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
   localparam logic signed [INTEG_WIDTH-1:0] INT_MIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};

   logic signed [EW-1:0]          now_ff, now_in;
   logic signed [EW-1:0]          prev_ff, prev_in;
   logic signed [INTEG_WIDTH-1:0] integ_ff, integ_in;
   logic signed [PW-1:0]          op_p_ff, op_p_in;
   logic signed [IOW-1:0]         op_i_ff, op_i_in;
   logic signed [DW-1:0]          op_d_ff, op_d_in;

   logic signed [PW-1:0]          diff1;
   logic signed [DW-1:0]          diff2;
   logic signed [SUMW-1:0]        acc;
   logic signed [INTEG_WIDTH-1:0] acc_sat;
   logic signed [INTEG_WIDTH-1:0] acc_cap;

   always_comb begin
      diff1 = PW'(err) - PW'(now_ff);
      // Second difference: new error minus twice the last one plus the one before.
      diff2 = DW'(err) - (DW'(now_ff) <<< 1) + DW'(prev_ff);

      acc = SUMW'(integ_ff) + SUMW'(err);
      if (acc > SUMW'(INT_MAX)) begin
         acc_sat = INT_MAX;
      end else if (acc < SUMW'(INT_MIN)) begin
         acc_sat = INT_MIN;
      end else begin
         acc_sat = acc[INTEG_WIDTH-1:0];
      end
      acc_cap = (acc_sat > integral_cap) ? integral_cap : acc_sat;

      now_in = err;
      if (mode == MODE_POSITIONAL) begin
         prev_in  = now_ff;
         integ_in = acc_cap;
         op_p_in  = PW'(err);
         op_i_in  = IOW'(acc_cap);
         op_d_in  = DW'(diff1);
      end else begin
         prev_in  = now_ff;
         integ_in = integ_ff;
         op_p_in  = diff1;
         op_i_in  = IOW'(err);
         op_d_in  = diff2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         prev_ff  <= '0;
         integ_ff <= '0;
      end else if (ctrl.ld_op) begin
         now_ff   <= now_in;
         prev_ff  <= prev_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_op) begin
         op_p_ff <= op_p_in;
         op_i_ff <= op_i_in;
         op_d_ff <= op_d_in;
      end
   end

   assign op_p = op_p_ff;
   assign op_i = op_i_ff;
   assign op_d = op_d_ff;

endmodule

`default_nettype wire

// ===== design/pidtm_terms.sv =====
// Product and sum stages: three products with the Q8.8 gains, then their sum floored to whole units.
`timescale 1ns / 1ps
`default_nettype none

module pidtm_terms import pidtm_pkg::*; #(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  wire logic                                        clock,
   input  wire pidtm_ctrl_type                              ctrl,
   input  wire logic signed [GAIN_WIDTH-1:0]                gain_p,
   input  wire logic signed [GAIN_WIDTH-1:0]                gain_i,
   input  wire logic signed [GAIN_WIDTH-1:0]                gain_d,
   input  wire logic signed [opp_width(SAMPLE_WIDTH)-1:0]   op_p,
   input  wire logic signed [opi_width(SAMPLE_WIDTH)-1:0]   op_i,
   input  wire logic signed [opd_width(SAMPLE_WIDTH)-1:0]   op_d,
   output logic signed [term_width(SAMPLE_WIDTH)-1:0]       sum
);

   localparam int PW  = opp_width(SAMPLE_WIDTH);
   localparam int DW  = opd_width(SAMPLE_WIDTH);
   localparam int IOW = opi_width(SAMPLE_WIDTH);
   localparam int TW  = term_width(SAMPLE_WIDTH);

   logic signed [GAIN_WIDTH+PW-1:0]  prod_p_ff, prod_p_in;
   logic signed [GAIN_WIDTH+IOW-1:0] prod_i_ff, prod_i_in;
   logic signed [GAIN_WIDTH+DW-1:0]  prod_d_ff, prod_d_in;
   logic signed [TW-1:0]             sum_full;
   logic signed [TW-1:0]             sum_ff, sum_in;

   always_comb begin
      prod_p_in = (GAIN_WIDTH+PW)'(gain_p) * (GAIN_WIDTH+PW)'(op_p);
      prod_i_in = (GAIN_WIDTH+IOW)'(gain_i) * (GAIN_WIDTH+IOW)'(op_i);
      prod_d_in = (GAIN_WIDTH+DW)'(gain_d) * (GAIN_WIDTH+DW)'(op_d);
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_prod) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
   end

   always_comb begin
      sum_full = TW'(prod_p_ff) + TW'(prod_i_ff) + TW'(prod_d_ff);
      // An arithmetic shift rounds toward minus infinity.
      sum_in   = sum_full >>> GAIN_FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

// ===== design/pidtm_checker.sv =====
// Port-level checks of the two-mode PID controller, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module pidtm_checker import pidtm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [DRIVE_WIDTH-1:0] rsp_tdata
);

   localparam int                 PIPE_DEPTH = 6;
   localparam int                 CNT_WIDTH  = $clog2(PIPE_DEPTH + 2);
   localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(PIPE_DEPTH);

   logic                 req_fire, rsp_fire;
   logic [CNT_WIDTH-1:0] pending_ff, pending_in;

   // Transactions accepted but not yet delivered.
   always_comb begin
      req_fire   = req_tvalid && req_tready;
      rsp_fire   = rsp_tvalid && rsp_tready;
      pending_in = pending_ff + CNT_WIDTH'(req_fire) - CNT_WIDTH'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A waiting result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("drive changed while stalled");

   // The input side is only held off when the whole pipeline is full and stalled.
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input held off without an output stall");

   // No result appears without an accepted sample behind it.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != '0)
      else $error("result without an accepted sample");

   // The pipeline never holds more samples than it has stages.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= DEPTH_CNT)
      else $error("more samples in flight than pipeline stages");

endmodule

bind pid_controller_two_mode pidtm_checker u_pidtm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
